@@ rtl/ngfp_pkg.sv @@
// Shared types, character codes and arithmetic constants of the GGA fix parser.
// Used by the front end, the line queue, the back end, the top level and the checker.
package ngfp_pkg;

	// Fraction digits kept per coordinate field (valid range 1 to 7).
	localparam int FRACTION_DIGITS = 5;

	localparam int WHOLE_W   = 17;
	localparam int WHOLE_MAX = 131071;
	localparam int FRAC_W    = $clog2(10 ** FRACTION_DIGITS);
	localparam int CNT_W     = 3;
	localparam int TIME_W    = 7;
	localparam int COORD_W   = 31;
	localparam int COORD_MAX = 1800000000;
	localparam int E7        = 10000000;
	localparam int E7_W      = $clog2(E7 + 1);

	// Degrees are the whole part divided by 100, done with a reciprocal multiply.
	localparam int DEG_W = $clog2(WHOLE_MAX / 100 + 1);
	localparam int DIV100_SHIFT = 27;
	localparam longint DIV100_K = ((longint'(1) << DIV100_SHIFT) + 99) / 100;
	localparam int DIV100_K_W = $clog2(DIV100_K + 1);
	localparam int DEG_E7_W = DEG_W + E7_W;

	// Minutes scaled to 1e7 per degree: floor(M * 10^7 / (60 * 10^F)).
	localparam int MIN_MUL = (FRACTION_DIGITS <= 6) ? 10 ** (6 - FRACTION_DIGITS) : 1;
	localparam int MIN_DIV = (FRACTION_DIGITS <= 6) ? 6 : 60;
	localparam int RECIP_SHIFT = (FRACTION_DIGITS <= 6) ? 33 : 36;
	localparam longint RECIP_K = ((longint'(1) << RECIP_SHIFT) + MIN_DIV - 1) / MIN_DIV;
	localparam int RECIP_W = $clog2(RECIP_K + 1);
	localparam int M_W = $clog2(longint'(101) * (10 ** FRACTION_DIGITS));
	localparam int N_W = $clog2(longint'(101) * (10 ** FRACTION_DIGITS) * MIN_MUL);
	localparam int SUM_W = DEG_E7_W + 1;

	// Local time arithmetic.
	localparam int MIN_PER_HOUR  = 60;
	localparam int HOURS_PER_DAY = 24;
	localparam int TIME_SAT      = 99;

	// Character codes.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_D0    = 8'h30;
	localparam logic [7:0] CHAR_D9    = 8'h39;
	localparam logic [47:0] TAG_PATTERN = 48'h24474E474741;

	// Field positions within a line.
	localparam logic [4:0] FIELD_TIME     = 5'd1;
	localparam logic [4:0] FIELD_LAT      = 5'd2;
	localparam logic [4:0] FIELD_LON      = 5'd4;
	localparam logic [4:0] FIX_MIN_FIELDS = 5'd5;
	localparam logic [4:0] FIELD_MAX      = 5'd31;
	localparam logic [2:0] TIME_DIGITS    = 3'd6;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int OFFSET_H_W = 5;
	localparam int OFFSET_M_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_HOURS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MINUTES = 1'b1;

	// Result stream layout, lowest bit first.
	localparam int TDATA_W   = 104;
	localparam int LAT_LSB   = 0;
	localparam int LON_LSB   = 31;
	localparam int UTC_H_LSB = 62;
	localparam int UTC_M_LSB = 69;
	localparam int UTC_S_LSB = 76;
	localparam int LOC_H_LSB = 83;
	localparam int LOC_M_LSB = 90;
	localparam int LOC_S_LSB = 97;

	// Line queue depth.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [CNT_W-1:0]   cnt;
	} coord_t;

	// One finished tagged line, as handed from the front end to the back end.
	typedef struct packed {
		logic        fix;
		coord_t      lat;
		coord_t      lon;
		logic [23:0] time_digits;
		logic [2:0]  time_cnt;
	} line_rec_t;

	typedef struct packed {
		logic [TIME_W-1:0] hour;
		logic [TIME_W-1:0] minute;
		logic [TIME_W-1:0] second;
		logic [TIME_W-1:0] local_hour;
		logic [TIME_W-1:0] local_minute;
	} time_t;

	function automatic logic [31:0] pow10(input logic [2:0] k);
		case (k)
			3'd0: return 32'd1;
			3'd1: return 32'd10;
			3'd2: return 32'd100;
			3'd3: return 32'd1000;
			3'd4: return 32'd10000;
			3'd5: return 32'd100000;
			3'd6: return 32'd1000000;
			3'd7: return 32'd10000000;
			default: return 32'd1;
		endcase
	endfunction

endpackage

@@ rtl/nmea_gga_fix_parser.sv @@
// The parser takes one received character per transfer on the s_ side, every cycle
// while s_tready is high, and reports one result on the m_ side for each newline that
// closes a line containing the "$GNGGA" tag: a fix with coordinates and times, or status
// 1 when there is no fix. A result passes through a six-stage arithmetic pipeline; a
// four-line queue in front of that pipeline lets input keep flowing while results wait,
// and s_tready drops only while that queue holds four finished lines, which can happen
// only while m_tready holds the pipeline back. Offsets are written through cfg_we,
// cfg_idx and cfg_wdata and take effect on every line that has not yet left stage 1.
// Depends on ngfp_pkg, ngfp_front, ngfp_queue and ngfp_back.
module nmea_gga_fix_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ngfp_pkg::TDATA_W-1:0]      m_tdata,   // lat_e7, lon_e7, utc_hour,
	                                                     // utc_minute, utc_second,
	                                                     // local_hour, local_minute,
	                                                     // local_second
	output logic                              m_tuser,   // status
	input  logic                              cfg_we,
	input  logic [ngfp_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ngfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import ngfp_pkg::*;

	logic [OFFSET_H_W-1:0] offset_hours_q;
	logic [OFFSET_M_W-1:0] offset_minutes_q;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	line_rec_t             wr_rec;
	line_rec_t             rd_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_hours_q   <= OFFSET_H_W'(5);
			offset_minutes_q <= OFFSET_M_W'(30);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OFFSET_HOURS:   offset_hours_q   <= cfg_wdata[OFFSET_H_W-1:0];
				CFG_OFFSET_MINUTES: offset_minutes_q <= cfg_wdata[OFFSET_M_W-1:0];
				default: ;
			endcase
		end
	end

	ngfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (wr_rec)
	);

	ngfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_rec (wr_rec),
		.full   (q_full),
		.pop    (q_pop),
		.rd_rec (rd_rec),
		.empty  (q_empty)
	);

	ngfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.q_rec          (rd_rec),
		.offset_hours   (offset_hours_q),
		.offset_minutes (offset_minutes_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

endmodule

@@ rtl/ngfp_front.sv @@
// Front end of the GGA fix parser: takes one byte per transfer, tracks the tag and fields,
// and pushes a line record into the queue at each newline of a tagged line. Uses ngfp_pkg.
module ngfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                q_full,
	output logic                q_push,
	output ngfp_pkg::line_rec_t q_rec
);
	import ngfp_pkg::*;

	logic [39:0]  tag_window_q;
	logic         tag_seen_q;
	logic [4:0]   field_count_q;
	logic [23:0]  time_digits_q;
	logic [2:0]   time_cnt_q;
	coord_t       lat_q;
	coord_t       lon_q;
	logic         lat_present_q;
	logic         after_point_q;

	logic         accept;
	logic         is_digit;
	logic [3:0]   digit;
	logic [47:0]  window;

	function automatic coord_t take_digit(input coord_t acc, input logic [3:0] d,
			input logic ap);
		coord_t r;
		logic [WHOLE_W+3:0] v;
		r = acc;
		v = (WHOLE_W+4)'(acc.whole) * (WHOLE_W+4)'(10) + (WHOLE_W+4)'(d);
		if (!ap) begin
			r.whole = (v > (WHOLE_W+4)'(WHOLE_MAX)) ? WHOLE_W'(WHOLE_MAX) : WHOLE_W'(v);
		end else if (acc.cnt < CNT_W'(FRACTION_DIGITS)) begin
			r.frac = FRAC_W'(acc.frac) * FRAC_W'(10) + FRAC_W'(d);
			r.cnt  = acc.cnt + CNT_W'(1);
		end
		return r;
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_digit = s_tdata inside {[CHAR_D0:CHAR_D9]};
	assign digit    = s_tdata[3:0];
	assign window   = {tag_window_q, s_tdata};

	assign q_push = accept && (s_tdata == CHAR_NL) && tag_seen_q;

	always_comb begin
		q_rec.fix         = (field_count_q >= FIX_MIN_FIELDS) && lat_present_q;
		q_rec.lat         = lat_q;
		q_rec.lon         = lon_q;
		q_rec.time_digits = time_digits_q;
		q_rec.time_cnt    = time_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_window_q  <= '0;
			tag_seen_q    <= 1'b0;
			field_count_q <= '0;
			time_digits_q <= '0;
			time_cnt_q    <= '0;
			lat_q         <= '0;
			lon_q         <= '0;
			lat_present_q <= 1'b0;
			after_point_q <= 1'b0;
		end else if (accept && (s_tdata != CHAR_NUL)) begin
			if (s_tdata == CHAR_NL) begin
				tag_window_q  <= '0;
				tag_seen_q    <= 1'b0;
				field_count_q <= '0;
				time_digits_q <= '0;
				time_cnt_q    <= '0;
				lat_q         <= '0;
				lon_q         <= '0;
				lat_present_q <= 1'b0;
				after_point_q <= 1'b0;
			end else begin
				tag_window_q <= window[39:0];
				if (window == TAG_PATTERN) begin
					tag_seen_q <= 1'b1;
				end
				if (s_tdata == CHAR_COMMA) begin
					if (field_count_q != FIELD_MAX) begin
						field_count_q <= field_count_q + 5'd1;
					end
					after_point_q <= 1'b0;
				end else begin
					case (field_count_q)
						FIELD_TIME: begin
							if (is_digit && (time_cnt_q < TIME_DIGITS)) begin
								time_digits_q[4*time_cnt_q +: 4] <= digit;
								time_cnt_q <= time_cnt_q + 3'd1;
							end
						end
						FIELD_LAT: begin
							lat_present_q <= 1'b1;
							if (is_digit) begin
								lat_q <= take_digit(lat_q, digit, after_point_q);
							end else if (s_tdata == CHAR_POINT) begin
								after_point_q <= 1'b1;
							end
						end
						FIELD_LON: begin
							if (is_digit) begin
								lon_q <= take_digit(lon_q, digit, after_point_q);
							end else if (s_tdata == CHAR_POINT) begin
								after_point_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

@@ rtl/ngfp_queue.sv @@
// Small line queue between the front end and the back end of the GGA fix parser.
// Holds whole line records in registers; depends on ngfp_pkg.
module ngfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ngfp_pkg::line_rec_t wr_rec,
	output logic                full,
	input  logic                pop,
	output ngfp_pkg::line_rec_t rd_rec,
	output logic                empty
);
	import ngfp_pkg::*;

	line_rec_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ rtl/ngfp_back.sv @@
// Back end of the GGA fix parser: a six-stage pipeline that turns a line record into
// decimal-degree coordinates and UTC and local time. Depends on ngfp_pkg.
module ngfp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  ngfp_pkg::line_rec_t           q_rec,
	input  logic [ngfp_pkg::OFFSET_H_W-1:0] offset_hours,
	input  logic [ngfp_pkg::OFFSET_M_W-1:0] offset_minutes,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ngfp_pkg::TDATA_W-1:0]  m_tdata,   // lat_e7, lon_e7, utc_hour,
	                                                 // utc_minute, utc_second, local_hour,
	                                                 // local_minute, local_second
	output logic                          m_tuser    // status
);
	import ngfp_pkg::*;

	localparam int DP_W = WHOLE_W + DIV100_K_W;
	localparam int QP_W = N_W + RECIP_W;

	logic en;

	// Stage 1: degrees by reciprocal, fraction scaled to full width, time pairs.
	logic               vld_s1, fix_s1;
	logic [WHOLE_W-1:0] whole_s1  [2];
	logic [DEG_W-1:0]   deg_s1    [2];
	logic [FRAC_W-1:0]  scaled_s1 [2];
	time_t              tm_s1;
	// Stage 2: minutes of the whole part, degrees times 1e7, local minute.
	logic               vld_s2, fix_s2;
	logic [6:0]         mm_s2     [2];
	logic [DEG_E7_W-1:0] dege7_s2 [2];
	logic [FRAC_W-1:0]  scaled_s2 [2];
	logic [7:0]         lh_raw_s2;
	time_t              tm_s2;
	// Stage 3: minutes as one fixed-point value, local hour.
	logic               vld_s3, fix_s3;
	logic [M_W-1:0]     minv_s3   [2];
	logic [DEG_E7_W-1:0] dege7_s3 [2];
	time_t              tm_s3;
	// Stage 4: minutes scaled toward the division.
	logic               vld_s4, fix_s4;
	logic [N_W-1:0]     n_s4      [2];
	logic [DEG_E7_W-1:0] dege7_s4 [2];
	time_t              tm_s4;
	// Stage 5: division by reciprocal.
	logic               vld_s5, fix_s5;
	logic [N_W-1:0]     q_s5      [2];
	logic [DEG_E7_W-1:0] dege7_s5 [2];
	time_t              tm_s5;
	// Stage 6: output register.
	logic               vld_s6, status_s6;
	logic [COORD_W-1:0] coord_s6  [2];
	time_t              tm_s6;
	logic [TIME_W-1:0]  sec_s6;

	coord_t             src       [2];
	logic [DEG_W-1:0]   deg_c     [2];
	logic [FRAC_W-1:0]  scaled_c  [2];
	logic [DP_W-1:0]    deg_prod  [2];
	logic [QP_W-1:0]    q_prod    [2];
	logic [SUM_W-1:0]   sum_c     [2];
	logic [COORD_W-1:0] coord_c   [2];
	time_t              tm_c1;
	time_t              tm_c2;
	time_t              tm_c3;
	logic [7:0]         lm_raw;
	logic               lm_carry;
	logic [7:0]         lm_adj;
	logic [7:0]         lh_adj;

	function automatic logic [TIME_W-1:0] time_pair(input logic [23:0] digits,
			input logic [2:0] cnt, input int k);
		logic [3:0] d0;
		logic [3:0] d1;
		d0 = digits[8*k +: 4];
		d1 = digits[8*k+4 +: 4];
		if (cnt >= 3'(2*k + 2)) begin
			return TIME_W'(d0) * TIME_W'(10) + TIME_W'(d1);
		end else if (cnt == 3'(2*k + 1)) begin
			return TIME_W'(d0);
		end
		return '0;
	endfunction

	assign en       = !vld_s6 || m_tready;
	assign q_pop    = en && !q_empty;
	assign m_tvalid = vld_s6;
	assign m_tuser  = status_s6;
	assign m_tdata  = {sec_s6, tm_s6.local_minute, tm_s6.local_hour, tm_s6.second,
		tm_s6.minute, tm_s6.hour, coord_s6[1], coord_s6[0]};

	always_comb begin
		src[0] = q_rec.lat;
		src[1] = q_rec.lon;
		for (int i = 0; i < 2; i++) begin
			deg_prod[i] = DP_W'(src[i].whole) * DP_W'(DIV100_K);
			deg_c[i]    = DEG_W'(deg_prod[i] >> DIV100_SHIFT);
			scaled_c[i] = FRAC_W'(32'(src[i].frac) * pow10(CNT_W'(FRACTION_DIGITS) - src[i].cnt));
			q_prod[i]   = QP_W'(n_s4[i]) * QP_W'(RECIP_K);
			sum_c[i]    = SUM_W'(dege7_s5[i]) + SUM_W'(q_s5[i]);
			coord_c[i]  = (sum_c[i] > SUM_W'(COORD_MAX)) ? COORD_W'(COORD_MAX)
				: COORD_W'(sum_c[i]);
		end
		tm_c1.hour         = time_pair(q_rec.time_digits, q_rec.time_cnt, 0);
		tm_c1.minute       = time_pair(q_rec.time_digits, q_rec.time_cnt, 1);
		tm_c1.second       = time_pair(q_rec.time_digits, q_rec.time_cnt, 2);
		tm_c1.local_hour   = '0;
		tm_c1.local_minute = '0;
		// Local minute wraps once and carries into the hour.
		lm_raw   = 8'(tm_s1.minute) + 8'(offset_minutes);
		lm_carry = (lm_raw >= 8'(MIN_PER_HOUR));
		lm_adj   = lm_carry ? lm_raw - 8'(MIN_PER_HOUR) : lm_raw;
		lh_adj   = (lh_raw_s2 >= 8'(HOURS_PER_DAY)) ? lh_raw_s2 - 8'(HOURS_PER_DAY) : lh_raw_s2;
		tm_c2              = tm_s1;
		tm_c2.local_minute = (lm_adj > 8'(TIME_SAT)) ? TIME_W'(TIME_SAT) : TIME_W'(lm_adj);
		tm_c3              = tm_s2;
		tm_c3.local_hour   = (lh_adj > 8'(TIME_SAT)) ? TIME_W'(TIME_SAT) : TIME_W'(lh_adj);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fix_s1 <= q_rec.fix;
			tm_s1  <= tm_c1;
			for (int i = 0; i < 2; i++) begin
				whole_s1[i]  <= src[i].whole;
				deg_s1[i]    <= deg_c[i];
				scaled_s1[i] <= scaled_c[i];
			end

			fix_s2 <= fix_s1;
			tm_s2  <= tm_c2;
			lh_raw_s2 <= 8'(tm_s1.hour) + 8'(offset_hours) + 8'(lm_carry);
			for (int i = 0; i < 2; i++) begin
				mm_s2[i]     <= 7'(whole_s1[i] - WHOLE_W'(deg_s1[i]) * WHOLE_W'(100));
				dege7_s2[i]  <= DEG_E7_W'(deg_s1[i]) * DEG_E7_W'(E7);
				scaled_s2[i] <= scaled_s1[i];
			end

			fix_s3 <= fix_s2;
			tm_s3  <= tm_c3;
			for (int i = 0; i < 2; i++) begin
				minv_s3[i]  <= M_W'(mm_s2[i]) * M_W'(10 ** FRACTION_DIGITS) + M_W'(scaled_s2[i]);
				dege7_s3[i] <= dege7_s2[i];
			end

			fix_s4 <= fix_s3;
			tm_s4  <= tm_s3;
			for (int i = 0; i < 2; i++) begin
				n_s4[i]     <= N_W'(minv_s3[i]) * N_W'(MIN_MUL);
				dege7_s4[i] <= dege7_s3[i];
			end

			fix_s5 <= fix_s4;
			tm_s5  <= tm_s4;
			for (int i = 0; i < 2; i++) begin
				q_s5[i]     <= N_W'(q_prod[i] >> RECIP_SHIFT);
				dege7_s5[i] <= dege7_s4[i];
			end

			// A line without a fix reports status only, every other field zero.
			status_s6 <= !fix_s5;
			tm_s6     <= fix_s5 ? tm_s5 : '0;
			sec_s6    <= fix_s5 ? tm_s5.second : '0;
			for (int i = 0; i < 2; i++) begin
				coord_s6[i] <= fix_s5 ? coord_c[i] : '0;
			end
		end
	end

endmodule

@@ rtl/ngfp_checker.sv @@
// Port-level checks for the GGA fix parser, attached to the top level by bind.
// Depends on ngfp_pkg.
module ngfp_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ngfp_pkg::TDATA_W-1:0]    m_tdata,
	input logic                            m_tuser
);
	import ngfp_pkg::*;

	// A stalled result stays put until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A no-fix report carries nothing but its status.
	a_nofix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("no-fix result with nonzero fields");

	// Coordinates saturate at 180 degrees.
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LAT_LSB +: COORD_W] <= COORD_W'(COORD_MAX)
			&& m_tdata[LON_LSB +: COORD_W] <= COORD_W'(COORD_MAX))
		else $error("coordinate above saturation limit");

	// Local seconds follow UTC seconds, and local fields stay within two digits.
	a_local_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LOC_S_LSB +: TIME_W] == m_tdata[UTC_S_LSB +: TIME_W]
			&& m_tdata[LOC_H_LSB +: TIME_W] <= TIME_W'(TIME_SAT)
			&& m_tdata[LOC_M_LSB +: TIME_W] <= TIME_W'(TIME_SAT))
		else $error("local time out of range");

endmodule

bind nmea_gga_fix_parser ngfp_port_checks u_ngfp_checker (.*);
